// ===== src/assert_macros.svh =====
// Assertion helpers used by the top-level scan unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lssns_pkg.sv =====
package lssns_pkg;

	localparam int ADDR_W  = 20;
	localparam int OFF_W   = 12;
	localparam int ROW_W   = 7;
	localparam int NIB_W   = 6;
	localparam int PROW_W  = 6;
	localparam int COL_W   = 8;
	localparam int DATA_W  = 4;
	localparam int CIDX_W  = 2;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	typedef enum logic [CIDX_W-1:0] {
		REG_MAIN_BASE = 2'd0,
		REG_MENU_BASE = 2'd1,
		REG_LINE_OFF  = 2'd2,
		REG_SPLIT_ROW = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]       main_base;
		logic [ADDR_W-1:0]       menu_base;
		logic signed [OFF_W-1:0] line_offset;
		logic [PROW_W-1:0]       split_row;
	} cfg_t;

	typedef struct packed {
		logic              action;
		logic [DATA_W-1:0] nibble;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] fetch_addr;
		logic              pixels_valid;
		logic [PROW_W-1:0] pixel_row;
		logic [COL_W-1:0]  pixel_col;
		logic [DATA_W-1:0] pixel_mask;
		logic              frame_done;
	} result_t;

endpackage

// ===== src/lssns_in_stage.sv =====
module lssns_in_stage import lssns_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== src/lssns_scan.sv =====
module lssns_scan import lssns_pkg::*; #(
	parameter int DISPLAY_ROWS    = 64,
	parameter int VISIBLE_COLUMNS = 131,
	parameter int ROW_NIBBLES     = 34
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item_s1,
	input  cfg_t    cfg,
	output result_t res
);

	logic [ROW_W-1:0]        row_q;
	logic [NIB_W-1:0]        nib_q;
	logic [ADDR_W-1:0]       cur_q;
	logic [ADDR_W-1:0]       rstart_q;
	logic [ADDR_W-1:0]       lat_menu_q;
	logic signed [OFF_W-1:0] lat_off_q;
	logic [PROW_W-1:0]       lat_split_q;

	logic [ROW_W-1:0]  row_d;
	logic [NIB_W-1:0]  nib_d;
	logic [ADDR_W-1:0] cur_d;
	logic [ADDR_W-1:0] rstart_d;
	logic              latch;

	logic              running;
	logic [NIB_W:0]    nib_inc;
	logic [ROW_W-1:0]  row_inc;
	logic [ADDR_W-1:0] step_base;
	logic [ADDR_W-1:0] next_row_addr;
	logic [8:0]        col_base;
	logic [DATA_W-1:0] mask;

	assign running   = row_q < ROW_W'(DISPLAY_ROWS);
	assign nib_inc   = {1'b0, nib_q} + 1'b1;
	assign row_inc   = row_q + 1'b1;
	assign step_base = rstart_q + ADDR_W'(ROW_NIBBLES);
	assign col_base  = {1'b0, nib_q, 2'b00};

	// Main rows step by the row pitch plus the signed offset; the row after the
	// split jumps to the menu base; menu rows step by the pitch alone.
	always_comb begin
		if (row_q < {1'b0, lat_split_q}) begin
			next_row_addr = step_base + ADDR_W'(lat_off_q);
		end else if (row_q == {1'b0, lat_split_q}) begin
			next_row_addr = lat_menu_q;
		end else begin
			next_row_addr = step_base;
		end
	end

	always_comb begin
		for (int k = 0; k < DATA_W; k++) begin
			mask[k] = item_s1.nibble[k] && ((col_base + 9'(k)) < 9'(VISIBLE_COLUMNS));
		end
	end

	always_comb begin
		row_d    = row_q;
		nib_d    = nib_q;
		cur_d    = cur_q;
		rstart_d = rstart_q;
		latch    = 1'b0;
		res      = '0;
		if (item_s1.action == ACT_START) begin
			latch    = 1'b1;
			row_d    = '0;
			nib_d    = '0;
			cur_d    = cfg.main_base;
			rstart_d = cfg.main_base;
		end else if (running) begin
			res.pixels_valid = 1'b1;
			res.pixel_row    = row_q[PROW_W-1:0];
			res.pixel_col    = {nib_q, 2'b00};
			res.pixel_mask   = mask;
			cur_d            = cur_q + 1'b1;
			nib_d            = nib_inc[NIB_W-1:0];
			if (nib_inc >= (NIB_W+1)'(ROW_NIBBLES)) begin
				nib_d = '0;
				if (row_inc >= ROW_W'(DISPLAY_ROWS)) begin
					row_d          = ROW_W'(DISPLAY_ROWS);
					res.frame_done = 1'b1;
				end else begin
					row_d    = row_inc;
					rstart_d = next_row_addr;
					cur_d    = next_row_addr;
				end
			end
		end
		res.fetch_addr = cur_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= ROW_W'(DISPLAY_ROWS);
			nib_q       <= '0;
			cur_q       <= '0;
			rstart_q    <= '0;
			lat_menu_q  <= '0;
			lat_off_q   <= '0;
			lat_split_q <= '1;
		end else if (fire) begin
			row_q    <= row_d;
			nib_q    <= nib_d;
			cur_q    <= cur_d;
			rstart_q <= rstart_d;
			if (latch) begin
				lat_menu_q  <= cfg.menu_base;
				lat_off_q   <= cfg.line_offset;
				lat_split_q <= cfg.split_row;
			end
		end
	end

endmodule

// ===== src/lssns_out_stage.sv =====
module lssns_out_stage import lssns_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t res_q
);

	// Result register frees when empty or when its transfer completes.
	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_q <= res;
		end
	end

endmodule

// ===== src/lcd_split_screen_nibble_scan_unit.sv =====
// Channel  Handshake               Payload
// in       in_valid / in_stall     action, nibble
// out      out_valid / out_stall   fetch_addr, pixels_valid, pixel_row, pixel_col,
//                                  pixel_mask, frame_done
// cfg      cfg_we                  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low.
// Each item passes an input register, then one pass of scan logic into the
// result register; the scan state updates as the item leaves the input register.
// Reset: frame finished, addresses zero, registers 0, 0, 0, 63.
// out_stall holds a full result register and, once the input register is full too, in_stall.
`include "assert_macros.svh"

module lcd_split_screen_nibble_scan_unit import lssns_pkg::*; #(
	parameter int DISPLAY_ROWS    = 64,
	parameter int VISIBLE_COLUMNS = 131,
	parameter int ROW_NIBBLES     = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [DATA_W-1:0] nibble,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] fetch_addr,
	output logic              pixels_valid,
	output logic [PROW_W-1:0] pixel_row,
	output logic [COL_W-1:0]  pixel_col,
	output logic [DATA_W-1:0] pixel_mask,
	output logic              frame_done,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    fire;
	result_t res;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.main_base   <= '0;
			cfg_q.menu_base   <= '0;
			cfg_q.line_offset <= '0;
			cfg_q.split_row   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAIN_BASE: cfg_q.main_base   <= cfg_data;
				REG_MENU_BASE: cfg_q.menu_base   <= cfg_data;
				REG_LINE_OFF:  cfg_q.line_offset <= cfg_data[OFF_W-1:0];
				REG_SPLIT_ROW: cfg_q.split_row   <= cfg_data[PROW_W-1:0];
				default: ;
			endcase
		end
	end

	assign item_in.action = action;
	assign item_in.nibble = nibble;
	assign fire           = valid_s1 && advance;

	lssns_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lssns_scan #(
		.DISPLAY_ROWS    (DISPLAY_ROWS),
		.VISIBLE_COLUMNS (VISIBLE_COLUMNS),
		.ROW_NIBBLES     (ROW_NIBBLES)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	lssns_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign fetch_addr   = res_q.fetch_addr;
	assign pixels_valid = res_q.pixels_valid;
	assign pixel_row    = res_q.pixel_row;
	assign pixel_col    = res_q.pixel_col;
	assign pixel_mask   = res_q.pixel_mask;
	assign frame_done   = res_q.frame_done;

	`ASSERT_IMPL(a_stall_needs_item, in_stall, valid_s1, "input stalled with empty stage")
	`ASSERT_IMPL(a_done_has_pixels, out_valid && frame_done, pixels_valid,
		"frame end without pixels")
	`ASSERT_IMPL(a_idle_result_clear, out_valid && !pixels_valid,
		pixel_mask == '0 && pixel_col == '0 && pixel_row == '0,
		"pixel fields set without pixels")
	`ASSERT_NEXT(a_fire_loads_out, fire, out_valid, "accepted item lost before result")

endmodule
